// ===== hw/rtl/hpwsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwsm_pkg
// Shared types, register indexes and saturation helpers for the heading PID
// wheel speed mixer.
// ----------------------------------------------------------------------------
package hpwsm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MulAW    = 33;
  localparam int unsigned MulBW    = 18;
  localparam int unsigned MulPW    = MulAW + MulBW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP           = 3'd0,
    REG_KI           = 3'd1,
    REG_KD           = 3'd2,
    REG_BASE_SPEED   = 3'd3,
    REG_FORWARD_GAIN = 3'd4,
    REG_TURN_GAIN    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P,
    ST_I,
    ST_D,
    ST_F,
    ST_T,
    ST_W
  } seq_state_e;

  typedef enum logic [2:0] {
    MUL_KP_E,
    MUL_KI_E,
    MUL_KD_DE,
    MUL_BASE_FG,
    MUL_OMEGA_TG
  } mul_op_e;

  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    mul_op_e mul_op;
    logic    lat_p;
    logic    upd_int;
    logic    lat_omega;
    logic    lat_fwd;
    logic    lat_out;
  } ctrl_t;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [7:0]  base_speed;
    logic [15:0] forward_gain;
    logic [15:0] turn_gain;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] wheel_level(input logic signed [MulPW-1:0] q20);
    logic [7:0] r;
    if (q20[MulPW-1]) begin
      r = 8'd0;
    end else if (|q20[MulPW-2:28]) begin
      r = 8'hFF;
    end else begin
      r = q20[27:20];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hpwsm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwsm_regs
// Gain and speed setting registers written through the configuration channel.
// ----------------------------------------------------------------------------
module hpwsm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hpwsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hpwsm_pkg::CfgDataW-1:0] cfg_data_i,
  output hpwsm_pkg::cfg_t               cfg_o
);
  import hpwsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KP:           cfg_d.kp           = cfg_data_i;
        REG_KI:           cfg_d.ki           = cfg_data_i;
        REG_KD:           cfg_d.kd           = cfg_data_i;
        REG_BASE_SPEED:   cfg_d.base_speed   = cfg_data_i[7:0];
        REG_FORWARD_GAIN: cfg_d.forward_gain = cfg_data_i;
        REG_TURN_GAIN:    cfg_d.turn_gain    = cfg_data_i;
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp           <= 16'd5140;
      cfg_q.ki           <= 16'd94;
      cfg_q.kd           <= 16'd225;
      cfg_q.base_speed   <= 8'd10;
      cfg_q.forward_gain <= 16'd6400;
      cfg_q.turn_gain    <= 16'd608;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/hpwsm_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwsm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hpwsm_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [hpwsm_pkg::MulAW-1:0]  a_i,
  input  logic signed [hpwsm_pkg::MulBW-1:0]  b_i,
  output logic signed [hpwsm_pkg::MulPW-1:0]  prod_o
);
  import hpwsm_pkg::*;

  logic signed [MulPW-1:0] prod_q, prod_d;

  always_comb begin
    prod_d = prod_q;
    if (en_i) begin
      prod_d = MulPW'(a_i) * MulPW'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/hpwsm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwsm_seq
// Step sequencer that schedules the shared multiplier and the accumulate steps.
// ----------------------------------------------------------------------------
module hpwsm_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_busy_i,
  output hpwsm_pkg::ctrl_t ctrl_o
);
  import hpwsm_pkg::*;

  seq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_P;
      ST_P:    state_d = ST_I;
      ST_I:    state_d = ST_D;
      ST_D:    state_d = ST_F;
      ST_F:    state_d = ST_T;
      ST_T:    state_d = ST_W;
      ST_W:    if (!out_busy_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.mul_op = MUL_KP_E;
    case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_P: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_KP_E;
      end
      ST_I: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_KI_E;
        ctrl_o.lat_p  = 1'b1;
      end
      ST_D: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_op  = MUL_KD_DE;
        ctrl_o.upd_int = 1'b1;
      end
      ST_F: begin
        ctrl_o.mul_en    = 1'b1;
        ctrl_o.mul_op    = MUL_BASE_FG;
        ctrl_o.lat_omega = 1'b1;
      end
      ST_T: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_op  = MUL_OMEGA_TG;
        ctrl_o.lat_fwd = 1'b1;
      end
      ST_W:    ctrl_o.lat_out = !out_busy_i;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/heading_pid_wheel_speed_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_wheel_speed_mixer_core
// Heading PID controller with differential-drive wheel speed mixing.
//
// Usage:
//   s_axis carries one control tick per transaction: target and measured
//   heading. m_axis returns one result per tick: left and right wheel levels
//   and the saturated turn rate. The cfg channel writes gains and speed
//   settings by register index; it is always ready. The user must see
//   that it is written only while idle; the block does not enforce this.
//   The sequencer steps one shared 33x18 multiplier through five products
//   (P, I, D, forward term, turn term), and the input is ready only while
//   the sequencer is idle. A held result sits in the output register; a new
//   tick may be accepted meanwhile, and its final step waits until the
//   receiver takes the previous result.
//   Reset restores the default gains and clears the integral, the previous
//   error and the output valid flag.
// ----------------------------------------------------------------------------
module heading_pid_wheel_speed_mixer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // target_heading, measured_heading
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // left_speed, right_speed, turn_rate
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hpwsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hpwsm_pkg::CfgDataW-1:0] cfg_data_i
);
  import hpwsm_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;

  logic signed [16:0] err_q, err_d, prev_q, prev_d;
  logic signed [17:0] derr_q, derr_d;
  logic signed [21:0] p_q, p_d;
  logic signed [31:0] int_q, int_d, omega_q, omega_d;
  logic [23:0]        fwd_q, fwd_d;
  logic               out_valid_q, out_valid_d;
  logic [47:0]        out_data_q, out_data_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;
  logic signed [MulPW-1:0] fwd_q20, left_q20, right_q20;
  logic signed [33:0]      int_sum, omega_sum;
  logic                    in_fire;

  hpwsm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hpwsm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_valid_q && !m_axis_tready),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    case (ctrl.mul_op)
      MUL_KP_E: begin
        mul_a = $signed({17'd0, cfg.kp});
        mul_b = MulBW'(err_q);
      end
      MUL_KI_E: begin
        mul_a = $signed({17'd0, cfg.ki});
        mul_b = MulBW'(err_q);
      end
      MUL_KD_DE: begin
        mul_a = $signed({17'd0, cfg.kd});
        mul_b = derr_q;
      end
      MUL_BASE_FG: begin
        mul_a = $signed({25'd0, cfg.base_speed});
        mul_b = $signed({2'd0, cfg.forward_gain});
      end
      MUL_OMEGA_TG: begin
        mul_a = MulAW'(omega_q);
        mul_b = $signed({2'd0, cfg.turn_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hpwsm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign in_fire       = s_axis_tvalid && ctrl.in_ready;

  assign int_sum   = 34'(int_q) + 34'($signed(prod[33:12]));
  assign omega_sum = 34'(int_q) + 34'(p_q) + 34'($signed(prod[34:12]));
  assign fwd_q20   = $signed({15'd0, fwd_q, 12'd0});
  assign left_q20  = fwd_q20 - prod;
  assign right_q20 = fwd_q20 + prod;

  always_comb begin
    err_d       = err_q;
    derr_d      = derr_q;
    prev_d      = prev_q;
    p_d         = p_q;
    int_d       = int_q;
    omega_d     = omega_q;
    fwd_d       = fwd_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_fire) begin
      err_d  = 17'($signed(s_axis_tdata[15:0])) - 17'($signed(s_axis_tdata[31:16]));
      derr_d = 18'(err_d) - 18'(prev_q);
      prev_d = err_d;
    end
    if (ctrl.lat_p)     p_d     = prod[33:12];
    if (ctrl.upd_int)   int_d   = sat32(int_sum);
    if (ctrl.lat_omega) omega_d = sat32(omega_sum);
    if (ctrl.lat_fwd)   fwd_d   = prod[23:0];
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (ctrl.lat_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {omega_q, wheel_level(right_q20), wheel_level(left_q20)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      int_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      int_q       <= int_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q      <= err_d;
    derr_q     <= derr_d;
    p_q        <= p_d;
    omega_q    <= omega_d;
    fwd_q      <= fwd_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
